@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define BTPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define BTPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/btpc_pkg.sv @@
package btpc_pkg;

   localparam int TDivBits = 27;
   localparam int PDivBits = 32;

   localparam logic [11:0] B6Offset   = 12'd4000;
   localparam logic [11:0] PressRound = 12'd3791;
   localparam logic [11:0] SqCoeff    = 12'd3038;
   localparam logic [12:0] LinCoeff   = 13'd7357;
   localparam logic [15:0] ScaleBase  = 16'd50000;
   localparam logic [17:0] PressMax   = 18'h3FFFF;

   typedef enum logic [2:0] {
      CSR_AC_SIGNED   = 3'd0,
      CSR_AC_UNSIGNED = 3'd1,
      CSR_B_COEFFS    = 3'd2,
      CSR_M_COEFFS    = 3'd3,
      CSR_OSS         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                valid;
      logic [18:0]         rem;
      logic [TDivBits-1:0] nq;
      logic [18:0]         dmag;
      logic                neg;
      logic                tz;
      logic signed [17:0]  x1;
      logic [18:0]         up;
   } tdiv_type;

   typedef struct packed {
      logic                valid;
      logic [16:0]         rem;
      logic [PDivBits-1:0] nq;
      logic [16:0]         dmag;
      logic                big;
      logic                bz;
      logic                tz;
      logic [15:0]         temp;
   } pdiv_type;

endpackage

@@ rtl/core/baro_temp_pressure_compensation_top.sv @@
// Barometric sensor compensation, integer form, fully pipelined.
// Input channel req_*: one item holds a raw temperature and a raw pressure.
// Result channel rsp_*: compensated temperature in tenths of a degree, pressure
// in pascals, and an error flag in rsp_tuser that is set when a divisor was zero.
// Configuration channel csr_*: writes calibration words by register index; it is
// always ready and must only be used while no item is in flight.
// One item is accepted every cycle while the receiver keeps up. Most of the
// latency comes from the two restoring dividers, which resolve one quotient bit
// per pipeline stage (27 stages for temperature, 32 for pressure, each after a
// setup stage).
// Reset clears the calibration registers and every valid bit in the pipeline.
// When the receiver stalls a valid result, the whole pipeline holds and req_tready
// drops; nothing is lost or repeated and the result stays on rsp_tdata.
`include "assert_macros.svh"

module baro_temp_pressure_compensation_top import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // raw_temperature [15:0], raw_pressure [34:16], zero fill [39:35]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // temperature_tenths [15:0], pressure_pa [33:16], zero fill [39:34]
   output logic [39:0] rsp_tdata,
   // div_error [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] acs_ff, acu_ff;
   logic [31:0] bc_ff, mc_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acs_ff <= '0;
         acu_ff <= '0;
         bc_ff  <= '0;
         mc_ff  <= '0;
         oss_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_AC_SIGNED:   acs_ff <= csr_data;
            CSR_AC_UNSIGNED: acu_ff <= csr_data;
            CSR_B_COEFFS:    bc_ff  <= csr_data[31:0];
            CSR_M_COEFFS:    mc_ff  <= csr_data[31:0];
            CSR_OSS:         oss_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = $signed(acs_ff[15:0]);
   assign ac2 = $signed(acs_ff[31:16]);
   assign ac3 = $signed(acs_ff[47:32]);
   assign ac4 = acu_ff[15:0];
   assign ac5 = acu_ff[31:16];
   assign ac6 = acu_ff[47:32];
   assign b1  = $signed(bc_ff[15:0]);
   assign b2  = $signed(bc_ff[31:16]);
   assign mc  = $signed(mc_ff[15:0]);
   assign md  = $signed(mc_ff[31:16]);

   logic adv;
   logic rsp_tvalid_ff;
   logic [39:0] rsp_tdata_ff;
   logic [0:0]  rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Stage A: first temperature product.
   logic               a_valid_ff;
   logic signed [32:0] a_prod_ff;
   logic [18:0]        a_up_ff;
   logic signed [16:0] a_diff;
   logic signed [33:0] a_mul;
   logic signed [32:0] a_prod_in;

   assign a_diff    = $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, ac6});
   assign a_mul     = a_diff * $signed({1'b0, ac5});
   assign a_prod_in = a_mul[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
         a_prod_ff  <= a_prod_in;
         a_up_ff    <= req_tdata[34:16];
      end
   end

   // Temperature divider: setup stage and one quotient bit per stage.
   tdiv_type td_ff [0:TDivBits];
   tdiv_type td_in [0:TDivBits];

   logic signed [17:0]       b_x1;
   logic signed [18:0]       b_den;
   logic signed [TDivBits-1:0] b_num;

   assign b_x1  = a_prod_ff[32:15];
   assign b_den = $signed({b_x1[17], b_x1}) + $signed({{3{md[15]}}, md});
   assign b_num = $signed({mc, 11'b0});

   always_comb begin
      td_in[0].valid = a_valid_ff;
      td_in[0].rem   = '0;
      td_in[0].nq    = b_num[TDivBits-1] ? TDivBits'(-b_num) : TDivBits'(b_num);
      td_in[0].dmag  = b_den[18] ? 19'(-b_den) : 19'(b_den);
      td_in[0].neg   = b_num[TDivBits-1] ^ b_den[18];
      td_in[0].tz    = (b_den == '0);
      td_in[0].x1    = b_x1;
      td_in[0].up    = a_up_ff;
   end

   for (genvar k = 1; k <= TDivBits; k++) begin : g_tdiv
      logic [19:0] sh;
      logic        ge;
      assign sh = {td_ff[k-1].rem, td_ff[k-1].nq[TDivBits-1]};
      assign ge = (sh >= {1'b0, td_ff[k-1].dmag});
      always_comb begin
         td_in[k]     = td_ff[k-1];
         td_in[k].rem = ge ? 19'(sh - {1'b0, td_ff[k-1].dmag}) : sh[18:0];
         td_in[k].nq  = {td_ff[k-1].nq[TDivBits-2:0], ge};
      end
   end

   for (genvar k = 0; k <= TDivBits; k++) begin : g_tdiv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            td_ff[k].valid <= 1'b0;
         end else if (adv) begin
            td_ff[k] <= td_in[k];
         end
      end
   end

   // Stage C: signed quotient and B5.
   logic               c_valid_ff, c_tz_ff;
   logic signed [28:0] c_b5_ff;
   logic [18:0]        c_up_ff;
   logic signed [27:0] c_x2;
   logic signed [28:0] c_b5_in;

   assign c_x2 = td_ff[TDivBits].neg ? -$signed({1'b0, td_ff[TDivBits].nq})
                                     : $signed({1'b0, td_ff[TDivBits].nq});
   assign c_b5_in = $signed({{11{td_ff[TDivBits].x1[17]}}, td_ff[TDivBits].x1})
                  + $signed({c_x2[27], c_x2});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= td_ff[TDivBits].valid;
         c_tz_ff    <= td_ff[TDivBits].tz;
         c_b5_ff    <= c_b5_in;
         c_up_ff    <= td_ff[TDivBits].up;
      end
   end

   // Stage D: B6 and saturated temperature.
   logic               d_valid_ff, d_tz_ff;
   logic signed [29:0] d_b6_ff;
   logic [15:0]        d_temp_ff;
   logic [18:0]        d_up_ff;
   logic signed [29:0] d_b6_in, d_tsum;
   logic signed [25:0] d_t;
   logic [15:0]        d_temp_in;

   assign d_b6_in = $signed({c_b5_ff[28], c_b5_ff}) - $signed({18'b0, B6Offset});
   assign d_tsum  = $signed({c_b5_ff[28], c_b5_ff}) + 30'sd8;
   assign d_t     = d_tsum[29:4];

   always_comb begin
      if (d_t > 26'sd32767) begin
         d_temp_in = 16'h7FFF;
      end else if (d_t < -26'sd32768) begin
         d_temp_in = 16'h8000;
      end else begin
         d_temp_in = d_t[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
         d_tz_ff    <= c_tz_ff;
         d_b6_ff    <= d_b6_in;
         d_temp_ff  <= d_temp_in;
         d_up_ff    <= c_up_ff;
      end
   end

   // Stage E: products of B6.
   logic               e_valid_ff, e_tz_ff;
   logic signed [59:0] e_sq_ff;
   logic signed [45:0] e_ac2_ff, e_ac3_ff;
   logic [15:0]        e_temp_ff;
   logic [18:0]        e_up_ff;
   logic signed [59:0] e_sq_in;
   logic signed [45:0] e_ac2_in, e_ac3_in;

   assign e_sq_in  = d_b6_ff * d_b6_ff;
   assign e_ac2_in = ac2 * d_b6_ff;
   assign e_ac3_in = ac3 * d_b6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
         e_tz_ff    <= d_tz_ff;
         e_sq_ff    <= e_sq_in;
         e_ac2_ff   <= e_ac2_in;
         e_ac3_ff   <= e_ac3_in;
         e_temp_ff  <= d_temp_ff;
         e_up_ff    <= d_up_ff;
      end
   end

   // Stage F: scaled square and linear terms.
   logic               f_valid_ff, f_tz_ff;
   logic [45:0]        f_sq_ff;
   logic signed [34:0] f_x2a_ff;
   logic signed [32:0] f_x1b_ff;
   logic [15:0]        f_temp_ff;
   logic [18:0]        f_up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= e_valid_ff;
         f_tz_ff    <= e_tz_ff;
         f_sq_ff    <= e_sq_ff[57:12];
         f_x2a_ff   <= e_ac2_ff[45:11];
         f_x1b_ff   <= e_ac3_ff[45:13];
         f_temp_ff  <= e_temp_ff;
         f_up_ff    <= e_up_ff;
      end
   end

   // Stage G: B1 and B2 products.
   logic               g_valid_ff, g_tz_ff;
   logic signed [62:0] g_b2sq_ff, g_b1sq_ff;
   logic signed [34:0] g_x2a_ff;
   logic signed [32:0] g_x1b_ff;
   logic [15:0]        g_temp_ff;
   logic [18:0]        g_up_ff;
   logic signed [62:0] g_b2sq_in, g_b1sq_in;

   assign g_b2sq_in = b2 * $signed({1'b0, f_sq_ff});
   assign g_b1sq_in = b1 * $signed({1'b0, f_sq_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
         g_tz_ff    <= f_tz_ff;
         g_b2sq_ff  <= g_b2sq_in;
         g_b1sq_ff  <= g_b1sq_in;
         g_x2a_ff   <= f_x2a_ff;
         g_x1b_ff   <= f_x1b_ff;
         g_temp_ff  <= f_temp_ff;
         g_up_ff    <= f_up_ff;
      end
   end

   // Stage H: X3 for B3 and the B4 operand.
   logic               h_valid_ff, h_tz_ff;
   logic signed [52:0] h_x3a_ff;
   logic [31:0]        h_b4arg_ff;
   logic [15:0]        h_temp_ff;
   logic [18:0]        h_up_ff;
   logic signed [52:0] h_x3a_in;
   logic signed [47:0] h_sumb;
   logic [31:0]        h_b4arg_in;

   assign h_x3a_in = $signed({g_b2sq_ff[62], g_b2sq_ff[62:11]})
                   + $signed({{18{g_x2a_ff[34]}}, g_x2a_ff});
   assign h_sumb   = $signed({g_b1sq_ff[62], g_b1sq_ff[62:16]})
                   + $signed({{15{g_x1b_ff[32]}}, g_x1b_ff}) + 48'sd2;
   assign h_b4arg_in = h_sumb[33:2] + 32'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= g_valid_ff;
         h_tz_ff    <= g_tz_ff;
         h_x3a_ff   <= h_x3a_in;
         h_b4arg_ff <= h_b4arg_in;
         h_temp_ff  <= g_temp_ff;
         h_up_ff    <= g_up_ff;
      end
   end

   // Stage I: B3 modulo 2^32 and B4.
   logic               i_valid_ff, i_tz_ff;
   logic [31:0]        i_b3_ff;
   logic [16:0]        i_b4_ff;
   logic [15:0]        i_temp_ff;
   logic [18:0]        i_up_ff;
   logic [33:0]        i_v, i_sh;
   logic [47:0]        i_b4prod;

   assign i_v      = {{16{ac1[15]}}, ac1, 2'b00} + h_x3a_ff[33:0];
   assign i_sh     = (i_v << oss_ff) + 34'd2;
   assign i_b4prod = ac4 * h_b4arg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         i_valid_ff <= h_valid_ff;
         i_tz_ff    <= h_tz_ff;
         i_b3_ff    <= i_sh[33:2];
         i_b4_ff    <= i_b4prod[31:15];
         i_temp_ff  <= h_temp_ff;
         i_up_ff    <= h_up_ff;
      end
   end

   // Stage J: UP minus B3.
   logic               j_valid_ff, j_tz_ff;
   logic [31:0]        j_diff_ff;
   logic [16:0]        j_b4_ff;
   logic [15:0]        j_temp_ff;
   logic [31:0]        j_diff_in;

   assign j_diff_in = {13'b0, i_up_ff} - i_b3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
      end else if (adv) begin
         j_valid_ff <= i_valid_ff;
         j_tz_ff    <= i_tz_ff;
         j_diff_ff  <= j_diff_in;
         j_b4_ff    <= i_b4_ff;
         j_temp_ff  <= i_temp_ff;
      end
   end

   // Stage K: B7 modulo 2^32.
   logic               k_valid_ff, k_tz_ff;
   logic [31:0]        k_b7_ff;
   logic [16:0]        k_b4_ff;
   logic [15:0]        k_temp_ff;
   logic [15:0]        k_scale;
   logic [47:0]        k_prod;

   assign k_scale = ScaleBase >> oss_ff;
   assign k_prod  = j_diff_ff * k_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         k_valid_ff <= j_valid_ff;
         k_tz_ff    <= j_tz_ff;
         k_b7_ff    <= k_prod[31:0];
         k_b4_ff    <= j_b4_ff;
         k_temp_ff  <= j_temp_ff;
      end
   end

   // Pressure divider: setup stage and one quotient bit per stage.
   pdiv_type pd_ff [0:PDivBits];
   pdiv_type pd_in [0:PDivBits];

   always_comb begin
      pd_in[0].valid = k_valid_ff;
      pd_in[0].rem   = '0;
      pd_in[0].big   = k_b7_ff[31];
      pd_in[0].nq    = k_b7_ff[31] ? k_b7_ff : {k_b7_ff[30:0], 1'b0};
      pd_in[0].dmag  = k_b4_ff;
      pd_in[0].bz    = (k_b4_ff == '0);
      pd_in[0].tz    = k_tz_ff;
      pd_in[0].temp  = k_temp_ff;
   end

   for (genvar k = 1; k <= PDivBits; k++) begin : g_pdiv
      logic [17:0] sh;
      logic        ge;
      assign sh = {pd_ff[k-1].rem, pd_ff[k-1].nq[PDivBits-1]};
      assign ge = (sh >= {1'b0, pd_ff[k-1].dmag});
      always_comb begin
         pd_in[k]     = pd_ff[k-1];
         pd_in[k].rem = ge ? 17'(sh - {1'b0, pd_ff[k-1].dmag}) : sh[16:0];
         pd_in[k].nq  = {pd_ff[k-1].nq[PDivBits-2:0], ge};
      end
   end

   for (genvar k = 0; k <= PDivBits; k++) begin : g_pdiv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            pd_ff[k].valid <= 1'b0;
         end else if (adv) begin
            pd_ff[k] <= pd_in[k];
         end
      end
   end

   // Stage M: raw pressure estimate.
   logic        m_valid_ff, m_tz_ff, m_bz_ff;
   logic [32:0] m_p_ff;
   logic [15:0] m_temp_ff;
   logic [32:0] m_p_in;

   assign m_p_in = pd_ff[PDivBits].big ? {pd_ff[PDivBits].nq, 1'b0}
                                       : {1'b0, pd_ff[PDivBits].nq};

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= pd_ff[PDivBits].valid;
         m_tz_ff    <= pd_ff[PDivBits].tz;
         m_bz_ff    <= pd_ff[PDivBits].bz;
         m_p_ff     <= m_p_in;
         m_temp_ff  <= pd_ff[PDivBits].temp;
      end
   end

   // Stage N: correction products.
   logic        n_valid_ff, n_tz_ff, n_bz_ff;
   logic [49:0] n_sqp_ff;
   logic [45:0] n_lin_ff;
   logic [32:0] n_p_ff;
   logic [15:0] n_temp_ff;
   logic [49:0] n_sqp_in;
   logic [45:0] n_lin_in;

   assign n_sqp_in = m_p_ff[32:8] * m_p_ff[32:8];
   assign n_lin_in = m_p_ff * LinCoeff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= m_valid_ff;
         n_tz_ff    <= m_tz_ff;
         n_bz_ff    <= m_bz_ff;
         n_sqp_ff   <= n_sqp_in;
         n_lin_ff   <= n_lin_in;
         n_p_ff     <= m_p_ff;
         n_temp_ff  <= m_temp_ff;
      end
   end

   // Stage O: scaled correction terms.
   logic               o_valid_ff, o_tz_ff, o_bz_ff;
   logic [45:0]        o_y1_ff;
   logic signed [30:0] o_y2_ff;
   logic [32:0]        o_p_ff;
   logic [15:0]        o_temp_ff;
   logic [61:0]        o_y1prod;
   logic signed [46:0] o_neg;

   assign o_y1prod = n_sqp_ff * SqCoeff;
   assign o_neg    = -$signed({1'b0, n_lin_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= n_valid_ff;
         o_tz_ff    <= n_tz_ff;
         o_bz_ff    <= n_bz_ff;
         o_y1_ff    <= o_y1prod[61:16];
         o_y2_ff    <= o_neg[46:16];
         o_p_ff     <= n_p_ff;
         o_temp_ff  <= n_temp_ff;
      end
   end

   // Output stage: final correction, saturation and error handling.
   logic signed [47:0] p_sum;
   logic signed [48:0] p_final;
   logic [17:0]        p_sat;
   logic [39:0]        rsp_tdata_in;
   logic [0:0]         rsp_tuser_in;

   assign p_sum   = $signed({2'b0, o_y1_ff}) + $signed({{17{o_y2_ff[30]}}, o_y2_ff})
                  + $signed({36'b0, PressRound});
   assign p_final = $signed({16'b0, o_p_ff}) + $signed({{5{p_sum[47]}}, p_sum[47:4]});

   always_comb begin
      if (p_final < 49'sd0) begin
         p_sat = '0;
      end else if (p_final > $signed({31'b0, PressMax})) begin
         p_sat = PressMax;
      end else begin
         p_sat = p_final[17:0];
      end
      if (o_tz_ff) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = 1'b1;
      end else if (o_bz_ff) begin
         rsp_tdata_in = {24'b0, o_temp_ff};
         rsp_tuser_in = 1'b1;
      end else begin
         rsp_tdata_in = {6'b0, p_sat, o_temp_ff};
         rsp_tuser_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= o_valid_ff;
         rsp_tdata_ff  <= rsp_tdata_in;
         rsp_tuser_ff  <= rsp_tuser_in;
      end
   end

   `BTPC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid right after reset")
   `BTPC_ASSERT(a_trem, td_ff[TDivBits].valid && !td_ff[TDivBits].tz |-> td_ff[TDivBits].rem < td_ff[TDivBits].dmag, "temperature remainder not below divisor")
   `BTPC_ASSERT(a_prem, pd_ff[PDivBits].valid && !pd_ff[PDivBits].bz |-> pd_ff[PDivBits].rem < pd_ff[PDivBits].dmag, "pressure remainder not below divisor")
   `BTPC_ASSERT(a_tz_out, adv && o_valid_ff && o_tz_ff |=> rsp_tvalid && rsp_tuser[0] && rsp_tdata == '0, "zero temperature divisor not reported")

endmodule

@@ tb/baro_temp_pressure_compensation_top_tb.sv @@
module baro_temp_pressure_compensation_top_tb import btpc_pkg::*; ();

   typedef struct {
      logic [15:0] raw_temp;
      logic [18:0] raw_press;
   } sample_type;

   typedef struct {
      logic [15:0] temp_tenths;
      logic [17:0] press_pa;
      logic        div_err;
   } reading_type;

   localparam logic [2:0] CsrUnused = 3'd7;
   localparam longint B6Off = 4000;
   localparam longint SqMul = 3038;
   localparam longint LinMul = -7357;
   localparam longint RoundAdd = 3791;
   localparam int unsigned WatchdogLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   logic [47:0] cal_ac_signed = '0;
   logic [47:0] cal_ac_unsigned = '0;
   logic [31:0] cal_b = '0;
   logic [31:0] cal_m = '0;
   logic [1:0]  cal_oss = '0;

   sample_type  samples_to_send[$];
   reading_type readings_due[$];
   bit       idling_on = 1'b1;
   bit       sender_hold = 1'b0;
   int       mismatches = 0;
   int       send_gap = 0;
   int       recv_gap = 0;
   int unsigned quiet_cycles = 0;

   baro_temp_pressure_compensation_top u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic reading_type compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
      reading_type r;
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
      longint x1, x2, x3, b5, b6, b3, sq, p, t;
      bit [31:0] b4, b7, prod, lo, num, scale;
      ac1 = longint'($signed(cal_ac_signed[15:0]));
      ac2 = longint'($signed(cal_ac_signed[31:16]));
      ac3 = longint'($signed(cal_ac_signed[47:32]));
      ac4 = longint'(cal_ac_unsigned[15:0]);
      ac5 = longint'(cal_ac_unsigned[31:16]);
      ac6 = longint'(cal_ac_unsigned[47:32]);
      b1 = longint'($signed(cal_b[15:0]));
      b2 = longint'($signed(cal_b[31:16]));
      mc = longint'($signed(cal_m[15:0]));
      md = longint'($signed(cal_m[31:16]));
      ut = longint'(ut_raw);
      r = '{temp_tenths: '0, press_pa: '0, div_err: 1'b1};
      x1 = ((ut - ac6) * ac5) >>> 15;
      if (x1 + md == 0) return r;
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;
      t = (b5 + 8) >>> 4;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temp_tenths = t[15:0];
      b6 = b5 - B6Off;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (longint'(1) << cal_oss) + 2) >>> 2;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      x3 = x3 + 32768;
      lo = x3[31:0];
      prod = ac4[31:0] * lo;
      b4 = prod >> 15;
      if (b4 == 0) return r;
      lo = b3[31:0];
      b7 = {13'b0, up_raw} - lo;
      scale = 32'd50000 >> cal_oss;
      b7 = b7 * scale;
      if (b7 < 32'h8000_0000) begin
         num = b7 * 32'd2;
         num = num / b4;
         p = longint'(num);
      end else begin
         num = b7 / b4;
         p = longint'(num) * 2;
      end
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * SqMul) >>> 16;
      x2 = (LinMul * p) >>> 16;
      p = p + ((x1 + x2 + RoundAdd) >>> 4);
      if (p < 0) p = 0;
      if (p > 262143) p = 262143;
      r.press_pa = p[17:0];
      r.div_err = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin : drive_samples
      sample_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready)
            readings_due.push_back(compensate(req_tdata[15:0], req_tdata[34:16]));
         if (req_tvalid && !req_tready) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(0, 9);
            req_tvalid <= 1'b0;
         end else if (!sender_hold && samples_to_send.size() > 0) begin
            s = samples_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {5'b0, s.raw_press, s.raw_temp};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Timeout: no item moved for %0d cycles.", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: data %h flag %b", rsp_tdata, rsp_tuser);
            end else begin
               exp_r = readings_due.pop_front();
               if (rsp_tdata[15:0] !== exp_r.temp_tenths ||
                   rsp_tdata[33:16] !== exp_r.press_pa ||
                   rsp_tdata[39:34] !== 6'b0 || rsp_tuser[0] !== exp_r.div_err) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: temp %0d/%0d press %0d/%0d err %b/%b (exp/act)",
                              $signed(exp_r.temp_tenths), $signed(rsp_tdata[15:0]),
                              exp_r.press_pa, rsp_tdata[33:16],
                              exp_r.div_err, rsp_tuser[0]);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_AC_SIGNED:   cal_ac_signed = value;
         CSR_AC_UNSIGNED: cal_ac_unsigned = value;
         CSR_B_COEFFS:    cal_b = value[31:0];
         CSR_M_COEFFS:    cal_m = value[31:0];
         CSR_OSS:         cal_oss = value[1:0];
         default: ;
      endcase
   endtask

   task automatic load_cal(logic [47:0] acs, logic [47:0] acu, logic [31:0] bw,
                           logic [31:0] mw, logic [1:0] oss);
      write_csr(CSR_AC_SIGNED, acs);
      write_csr(CSR_AC_UNSIGNED, acu);
      write_csr(CSR_B_COEFFS, {16'hFFFF, bw});
      write_csr(CSR_M_COEFFS, {16'hFFFF, mw});
      write_csr(CSR_OSS, {{23{2'b01}}, oss});
      write_csr(CsrUnused, 48'({$urandom, $urandom}));
      csr_valid <= 1'b0;
   endtask

   // Settled values are checked away from the driving edge.
   task automatic wait_drained();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_tvalid || readings_due.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic add_sample(logic [15:0] ut, logic [18:0] up);
      samples_to_send.push_back('{raw_temp: ut, raw_press: up});
   endtask

   task automatic add_random(int n);
      repeat (n) begin
         if ($urandom_range(0, 3) != 0)
            add_sample(16'($urandom_range(20000, 36000)), 19'($urandom_range(0, 19'h7FFFF)));
         else
            add_sample(16'($urandom), 19'($urandom));
      end
   endtask

   localparam logic [47:0] TypAcS = {16'hC7D1, 16'hFFB8, 16'd408};
   localparam logic [47:0] TypAcU = {16'd23153, 16'd32757, 16'd32741};
   localparam logic [31:0] TypB = {16'd4, 16'd6190};
   localparam logic [31:0] TypM = {16'd2868, 16'hDDF9};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: the temperature divisor is zero.
      add_sample(16'd0, 19'd0);
      add_sample(16'hFFFF, 19'h7FFFF);
      wait_drained();

      load_cal(TypAcS, TypAcU, TypB, TypM, 2'd0);
      add_sample(16'd27898, 19'd23843);
      add_sample(16'd0, 19'd0);
      add_sample(16'hFFFF, 19'h7FFFF);
      add_sample(16'h5555, 19'h2AAAA);
      add_sample(16'hAAAA, 19'h55555);
      add_sample(16'd27898, 19'h7FFFF);
      add_sample(16'd27898, 19'd0);
      add_sample(16'd23153, 19'd40000);
      wait_drained();

      for (int o = 1; o < 4; o++) begin
         load_cal(TypAcS, TypAcU, TypB, TypM, o[1:0]);
         add_sample(16'd27898, 19'(23843 << o));
         add_sample(16'd30000, 19'h7FFFF);
         wait_drained();
      end

      // Pressure divisor zero via AC4, and temperature divisor zero via AC5 and MD.
      load_cal(TypAcS, {TypAcU[47:16], 16'd0}, TypB, TypM, 2'd0);
      add_sample(16'd27898, 19'd23843);
      add_sample(16'hFFFF, 19'd100);
      wait_drained();
      load_cal(TypAcS, {TypAcU[47:32], 16'd0, TypAcU[15:0]}, TypB, {16'd0, TypM[15:0]}, 2'd0);
      add_sample(16'd27898, 19'd23843);
      wait_drained();

      load_cal('1, '1, '1, '1, 2'd3);
      add_sample(16'd0, 19'd0);
      add_sample(16'hFFFF, 19'h7FFFF);
      add_random(20);
      wait_drained();
      load_cal({3{16'h8000}}, {3{16'h8000}}, {2{16'h8000}}, {2{16'h7FFF}}, 2'd2);
      add_sample(16'd0, 19'h7FFFF);
      add_random(20);
      wait_drained();

      // Typical calibration with the sender paused midway until all results are in.
      load_cal(TypAcS, TypAcU, TypB, TypM, 2'd0);
      add_random(100);
      wait (samples_to_send.size() == 0 && !req_tvalid);
      sender_hold = 1'b1;
      wait (readings_due.size() == 0);
      add_random(100);
      sender_hold = 1'b0;
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 2 == 0)
            load_cal(TypAcS ^ 48'($urandom_range(0, 255)), TypAcU ^ 48'($urandom_range(0, 255)),
                     TypB ^ $urandom_range(0, 63), TypM ^ $urandom_range(0, 255),
                     2'($urandom_range(0, 3)));
         else
            load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                     2'($urandom_range(0, 3)));
         if (ph == 9) idling_on = 1'b0;
         add_random(139);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && readings_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
